>>> src/lcs_pkg.sv
package lcs_pkg;

    // Datapath width of a, b and m; the ports are fixed at this width.
    localparam int WIDTH    = 16;
    // Longest list of solutions given for one item.
    localparam int MAX_LIST = 64;
    // Width of the solution index field.
    localparam int IDX_W    = 6;
    // Signed width of the Bezout coefficients in the inverse search.
    localparam int T_W      = WIDTH + 2;
    // Iteration counter of the divider, able to hold 2*WIDTH.
    localparam int CNT_W    = $clog2(2 * WIDTH + 1);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSOL   = 2'd1;
    localparam logic [1:0] ST_MODZERO = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GCD,
        S_BDIV,
        S_ADIV,
        S_MDIV,
        S_INV_INIT,
        S_INV_LOOP,
        S_INV_FIX,
        S_BMOD,
        S_MUL,
        S_XMOD,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic                   start;
        logic                   long_mode;
        logic [2*WIDTH-1:0]     dividend;
        logic [WIDTH-1:0]       divisor;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic [WIDTH-1:0]       quot;
        logic [WIDTH-1:0]       rem;
    } div_rsp_t;

endpackage

>>> src/lcs_divider.sv
module lcs_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  lcs_pkg::div_req_t req,
    output lcs_pkg::div_rsp_t rsp
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [lcs_pkg::CNT_W-1:0]     cnt_reg;
    logic [2*lcs_pkg::WIDTH-1:0]   dvd_reg;
    logic [lcs_pkg::WIDTH-1:0]     rem_reg;
    logic [lcs_pkg::WIDTH-1:0]     dsr_reg;

    logic [lcs_pkg::WIDTH:0]       shifted;
    logic [lcs_pkg::WIDTH:0]       diff;
    logic                          qbit;
    logic [lcs_pkg::WIDTH-1:0]     rem_next;

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    always_comb begin
        shifted  = {rem_reg, dvd_reg[2*lcs_pkg::WIDTH-1]};
        diff     = shifted - {1'b0, dsr_reg};
        qbit     = (shifted >= {1'b0, dsr_reg});
        rem_next = qbit ? diff[lcs_pkg::WIDTH-1:0] : shifted[lcs_pkg::WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.long_mode ? lcs_pkg::CNT_W'(2 * lcs_pkg::WIDTH)
                                          : lcs_pkg::CNT_W'(lcs_pkg::WIDTH);
                dvd_reg  <= req.long_mode ? req.dividend
                                          : {req.dividend[lcs_pkg::WIDTH-1:0],
                                             {lcs_pkg::WIDTH{1'b0}}};
                rem_reg  <= '0;
                dsr_reg  <= req.divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[2*lcs_pkg::WIDTH-2:0], qbit};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == lcs_pkg::CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = dvd_reg[lcs_pkg::WIDTH-1:0];
    assign rsp.rem  = rem_reg;

    a_done_follows_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_reg && dsr_reg != '0) |-> (rem_reg < dsr_reg))
        else $error("divider remainder not below divisor");

endmodule

>>> src/linear_congruence_solver.sv
// Linear congruence solver: solves a*x == b (mod m) for unsigned 16-bit a, b, m.
//
// Input channel (s_valid/s_ready) takes one item {coef_a, rhs_b, modulus}.
// s_ready is high only while the block is idle; one item is worked at a time.
// Result channel (m_valid/m_ready) gives one or more items per input:
//   - modulus zero: one result, status 2, last set.
//   - gcd(a, m) does not divide b: one result, status 1, last set.
//   - otherwise min(d, 64) solutions x0 + m'*k, k counting up, last on the
//     final one, truncated on every one when d exceeds 64.
// All divisions run through one shared restoring divider, one quotient bit
// per cycle; it divides 16 bits wide, and 32 bits wide for the reduction of
// b'*inv. The time to an item's first result grows with the number of Euclid
// steps for gcd(a, m) and of extended Euclid steps for the inverse; then the
// results follow back to back while the receiver takes them.
// A stalled receiver holds the current result steady; the sequencer waits.
// Reset (aresetn low at a clock edge) drops any item in flight and returns
// the block to idle with no result pending.
module linear_congruence_solver (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lcs_pkg::WIDTH-1:0]   s_coef_a,
    input  logic [lcs_pkg::WIDTH-1:0]   s_rhs_b,
    input  logic [lcs_pkg::WIDTH-1:0]   s_modulus,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [lcs_pkg::WIDTH-1:0]   m_solution,
    output logic [lcs_pkg::IDX_W-1:0]   m_solution_index,
    output logic                        m_last,
    output logic                        m_truncated
);

    localparam int W = lcs_pkg::WIDTH;
    localparam int T = lcs_pkg::T_W;
    localparam int I = lcs_pkg::IDX_W;

    lcs_pkg::state_t state_reg, state_next;
    logic                 pend_reg, pend_next;
    logic [W-1:0]         a_reg, a_next;
    logic [W-1:0]         b_reg, b_next;
    logic [W-1:0]         m_reg, m_next;
    logic [W-1:0]         x_reg, x_next;      // gcd / remainder r0
    logic [W-1:0]         y_reg, y_next;      // gcd / remainder r1
    logic [W-1:0]         d_reg, d_next;
    logic [W-1:0]         br_reg, br_next;
    logic [W-1:0]         ar_reg, ar_next;
    logic [W-1:0]         mr_reg, mr_next;
    logic signed [T-1:0]  t0_reg, t0_next;
    logic signed [T-1:0]  t1_reg, t1_next;
    logic [W-1:0]         inv_reg, inv_next;
    logic [W-1:0]         bm_reg, bm_next;
    logic [2*W-1:0]       prod_reg, prod_next;
    logic                 valid_reg, valid_next;
    logic [1:0]           status_reg, status_next;
    logic [W-1:0]         sol_reg, sol_next;
    logic [I-1:0]         idx_reg, idx_next;
    logic [I-1:0]         last_idx_reg, last_idx_next;
    logic                 cut_reg, cut_next;

    lcs_pkg::div_req_t div_req;
    lcs_pkg::div_rsp_t div_rsp;

    logic                 div_state;
    logic                 div_skip;
    logic                 div_done;
    logic signed [T-1:0]  q_ext;
    logic signed [T-1:0]  qt_prod;
    logic signed [T-1:0]  t_pos;
    logic signed [T-1:0]  mr_ext;
    logic                 is_cut;

    lcs_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Pick operands of the shared divider by sequencer state.
    always_comb begin
        div_req.long_mode = 1'b0;
        div_req.dividend  = '0;
        div_req.divisor   = mr_reg;
        div_state         = 1'b1;
        div_skip          = 1'b0;
        unique case (state_reg)
            lcs_pkg::S_GCD: begin
                div_req.dividend = {{W{1'b0}}, x_reg};
                div_req.divisor  = y_reg;
            end
            lcs_pkg::S_BDIV: begin
                div_req.dividend = {{W{1'b0}}, b_reg};
                div_req.divisor  = d_reg;
            end
            lcs_pkg::S_ADIV: begin
                div_req.dividend = {{W{1'b0}}, a_reg};
                div_req.divisor  = d_reg;
            end
            lcs_pkg::S_MDIV: begin
                div_req.dividend = {{W{1'b0}}, m_reg};
                div_req.divisor  = d_reg;
            end
            lcs_pkg::S_INV_INIT: begin
                div_req.dividend = {{W{1'b0}}, ar_reg};
                div_skip         = (mr_reg <= W'(1));
            end
            lcs_pkg::S_INV_LOOP: begin
                div_req.dividend = {{W{1'b0}}, x_reg};
                div_req.divisor  = y_reg;
                div_skip         = (y_reg == '0);
            end
            lcs_pkg::S_BMOD: begin
                div_req.dividend = {{W{1'b0}}, br_reg};
            end
            lcs_pkg::S_XMOD: begin
                div_req.long_mode = 1'b1;
                div_req.dividend  = prod_reg;
            end
            default: begin
                div_state = 1'b0;
            end
        endcase
        div_req.start = div_state && !div_skip && !pend_reg;
        div_done      = pend_reg && div_rsp.done;
    end

    // Bezout update, inverse normalization and the list-length check.
    always_comb begin
        q_ext   = signed'({{(T-W){1'b0}}, div_rsp.quot});
        qt_prod = q_ext * t1_reg;
        mr_ext  = signed'({{(T-W){1'b0}}, mr_reg});
        t_pos   = (t0_reg < 0) ? (t0_reg + mr_ext) : t0_reg;
        is_cut  = (d_reg > W'(lcs_pkg::MAX_LIST));
    end

    // Sequencer: next state and datapath updates.
    always_comb begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        m_next        = m_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        d_next        = d_reg;
        br_next       = br_reg;
        ar_next       = ar_reg;
        mr_next       = mr_reg;
        t0_next       = t0_reg;
        t1_next       = t1_reg;
        inv_next      = inv_reg;
        bm_next       = bm_reg;
        prod_next     = prod_reg;
        valid_next    = valid_reg;
        status_next   = status_reg;
        sol_next      = sol_reg;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        cut_next      = cut_reg;

        if (div_req.start) begin
            pend_next = 1'b1;
        end
        if (div_done) begin
            pend_next = 1'b0;
        end

        unique case (state_reg)
            lcs_pkg::S_IDLE: begin
                if (s_valid) begin
                    a_next = s_coef_a;
                    b_next = s_rhs_b;
                    m_next = s_modulus;
                    x_next = s_coef_a;
                    y_next = s_modulus;
                    if (s_modulus == '0) begin
                        status_next   = lcs_pkg::ST_MODZERO;
                        sol_next      = '0;
                        idx_next      = '0;
                        last_idx_next = '0;
                        cut_next      = 1'b0;
                        valid_next    = 1'b1;
                        state_next    = lcs_pkg::S_EMIT;
                    end else begin
                        state_next = lcs_pkg::S_GCD;
                    end
                end
            end
            lcs_pkg::S_GCD: begin
                if (div_done) begin
                    x_next = y_reg;
                    y_next = div_rsp.rem;
                    if (div_rsp.rem == '0) begin
                        d_next     = y_reg;
                        state_next = lcs_pkg::S_BDIV;
                    end
                end
            end
            lcs_pkg::S_BDIV: begin
                if (div_done) begin
                    br_next = div_rsp.quot;
                    if (div_rsp.rem != '0) begin
                        status_next   = lcs_pkg::ST_NOSOL;
                        sol_next      = '0;
                        idx_next      = '0;
                        last_idx_next = '0;
                        cut_next      = 1'b0;
                        valid_next    = 1'b1;
                        state_next    = lcs_pkg::S_EMIT;
                    end else begin
                        state_next = lcs_pkg::S_ADIV;
                    end
                end
            end
            lcs_pkg::S_ADIV: begin
                if (div_done) begin
                    ar_next    = div_rsp.quot;
                    state_next = lcs_pkg::S_MDIV;
                end
            end
            lcs_pkg::S_MDIV: begin
                if (div_done) begin
                    mr_next    = div_rsp.quot;
                    state_next = lcs_pkg::S_INV_INIT;
                end
            end
            lcs_pkg::S_INV_INIT: begin
                if (div_skip) begin
                    // Reduced modulus one: inverse taken as zero.
                    inv_next   = '0;
                    state_next = lcs_pkg::S_BMOD;
                end else if (div_done) begin
                    x_next     = mr_reg;
                    y_next     = div_rsp.rem;
                    t0_next    = '0;
                    t1_next    = T'(1);
                    state_next = lcs_pkg::S_INV_LOOP;
                end
            end
            lcs_pkg::S_INV_LOOP: begin
                if (div_skip) begin
                    state_next = lcs_pkg::S_INV_FIX;
                end else if (div_done) begin
                    x_next  = y_reg;
                    y_next  = div_rsp.rem;
                    t0_next = t1_reg;
                    t1_next = t0_reg - qt_prod;
                end
            end
            lcs_pkg::S_INV_FIX: begin
                inv_next   = (t_pos >= mr_ext) ? W'(t_pos - mr_ext) : W'(t_pos);
                state_next = lcs_pkg::S_BMOD;
            end
            lcs_pkg::S_BMOD: begin
                if (div_done) begin
                    bm_next    = div_rsp.rem;
                    state_next = lcs_pkg::S_MUL;
                end
            end
            lcs_pkg::S_MUL: begin
                prod_next  = bm_reg * inv_reg;
                state_next = lcs_pkg::S_XMOD;
            end
            lcs_pkg::S_XMOD: begin
                if (div_done) begin
                    status_next   = lcs_pkg::ST_OK;
                    sol_next      = div_rsp.rem;
                    idx_next      = '0;
                    cut_next      = is_cut;
                    last_idx_next = is_cut ? I'(lcs_pkg::MAX_LIST - 1)
                                           : (d_reg[I-1:0] - 1'b1);
                    valid_next    = 1'b1;
                    state_next    = lcs_pkg::S_EMIT;
                end
            end
            lcs_pkg::S_EMIT: begin
                if (m_ready) begin
                    if (idx_reg == last_idx_reg) begin
                        valid_next = 1'b0;
                        state_next = lcs_pkg::S_IDLE;
                    end else begin
                        // Advance to the next solution of the list.
                        idx_next = idx_reg + 1'b1;
                        sol_next = sol_reg + mr_reg;
                    end
                end
            end
            default: begin
                state_next = lcs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lcs_pkg::S_IDLE;
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        m_reg        <= m_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        d_reg        <= d_next;
        br_reg       <= br_next;
        ar_reg       <= ar_next;
        mr_reg       <= mr_next;
        t0_reg       <= t0_next;
        t1_reg       <= t1_next;
        inv_reg      <= inv_next;
        bm_reg       <= bm_next;
        prod_reg     <= prod_next;
        status_reg   <= status_next;
        sol_reg      <= sol_next;
        idx_reg      <= idx_next;
        last_idx_reg <= last_idx_next;
        cut_reg      <= cut_next;
    end

    assign s_ready          = (state_reg == lcs_pkg::S_IDLE);
    assign m_valid          = valid_reg;
    assign m_status         = status_reg;
    assign m_solution       = sol_reg;
    assign m_solution_index = idx_reg;
    assign m_last           = (idx_reg == last_idx_reg);
    assign m_truncated      = cut_reg;

    a_valid_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (state_reg == lcs_pkg::S_EMIT))
        else $error("result shown outside the emit state");

    a_error_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && status_reg != lcs_pkg::ST_OK)
            |-> (m_last && sol_reg == '0 && idx_reg == '0 && !cut_reg))
        else $error("error result is not a single zero item");

    a_index_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && m_ready && !m_last)
            |=> (valid_reg && idx_reg == $past(idx_reg) + 1'b1))
        else $error("solution index did not advance by one");

    a_no_div_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_reg)
        else $error("division pending while idle");

endmodule

>>> tb/linear_congruence_solver_tb.sv
`timescale 1ns / 100ps

module linear_congruence_solver_tb;

    localparam int WIDTH    = lcs_pkg::WIDTH;
    localparam int IDX_W    = lcs_pkg::IDX_W;
    localparam int MAX_LIST = lcs_pkg::MAX_LIST;

    typedef logic [WIDTH-1:0] word_t;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [1:0]       status;
        logic [WIDTH-1:0] solution;
        logic [IDX_W-1:0] index;
        logic             last;
        logic             truncated;
    } solution_t;

    // One row of the directed table. Rows with known_result set carry the single
    // result that can be read off directly; the rest go through the predictor.
    typedef struct packed {
        logic [WIDTH-1:0] coef_a;
        logic [WIDTH-1:0] rhs_b;
        logic [WIDTH-1:0] modulus;
        logic             known_result;
        logic [1:0]       status;
        logic [WIDTH-1:0] solution;
    } congruence_row_t;

    localparam int NUM_ROWS     = 20;
    localparam int RANDOM_ITEMS = 100;
    localparam int LONG_HOLD    = 3000;
    localparam int SETTLE       = 1200;
    localparam int CYCLE_LIMIT  = 2_500_000;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [WIDTH-1:0] s_coef_a;
    logic [WIDTH-1:0] s_rhs_b;
    logic [WIDTH-1:0] s_modulus;
    logic             m_valid;
    logic             m_ready;
    logic [1:0]       m_status;
    logic [WIDTH-1:0] m_solution;
    logic [IDX_W-1:0] m_solution_index;
    logic             m_last;
    logic             m_truncated;

    // Solutions still owed by the block, oldest first.
    solution_t pending_solutions[$];
    int        mismatch_count = 0;
    int        results_seen   = 0;
    int        cycle_count    = 0;
    // Set while both sides run without idling.
    bit        calm           = 1'b0;

    // Directed cases: error codes, extremes of every field, coefficient zero,
    // reduced modulus one, lists right at and past the list limit, and the
    // slowest Euclid chains (consecutive Fibonacci numbers).
    congruence_row_t congruence_rows [NUM_ROWS] = '{
        '{16'h0000, 16'h0000, 16'h0000, 1'b1, lcs_pkg::ST_MODZERO, 16'd0},
        '{16'hffff, 16'hffff, 16'h0000, 1'b1, lcs_pkg::ST_MODZERO, 16'd0},
        '{16'd2,    16'd1,    16'd4,    1'b1, lcs_pkg::ST_NOSOL,   16'd0},
        '{16'd1,    16'd5,    16'd7,    1'b1, lcs_pkg::ST_OK,      16'd5},
        '{16'd0,    16'd0,    16'd1,    1'b1, lcs_pkg::ST_OK,      16'd0},
        '{16'd0,    16'd5,    16'd7,    1'b1, lcs_pkg::ST_NOSOL,   16'd0},
        '{16'd7,    16'hffff, 16'd1,    1'b1, lcs_pkg::ST_OK,      16'd0},
        '{16'd0,    16'd14,   16'd7,    1'b0, lcs_pkg::ST_OK,      16'd0},
        '{16'hffff, 16'hffff, 16'hffff, 1'b0, lcs_pkg::ST_OK,      16'd0},
        '{16'd0,    16'd0,    16'hffff, 1'b0, lcs_pkg::ST_OK,      16'd0},
        '{16'd3,    16'd0,    16'hffff, 1'b0, lcs_pkg::ST_OK,      16'd0},
        '{16'hffff, 16'd1,    16'hfffe, 1'b0, lcs_pkg::ST_OK,      16'd0},
        '{16'd6,    16'd4,    16'd10,   1'b0, lcs_pkg::ST_OK,      16'd0},
        '{16'd64,   16'd0,    16'd4096, 1'b0, lcs_pkg::ST_OK,      16'd0},
        '{16'd65,   16'd130,  16'd65000,1'b0, lcs_pkg::ST_OK,      16'd0},
        '{16'd28657,16'd1,    16'd46368,1'b0, lcs_pkg::ST_OK,      16'd0},
        '{16'd46368,16'd1234, 16'd28657,1'b0, lcs_pkg::ST_OK,      16'd0},
        '{16'd12345,16'd54321,16'd65521,1'b0, lcs_pkg::ST_OK,      16'd0},
        '{16'd2,    16'd3,    16'hffff, 1'b0, lcs_pkg::ST_OK,      16'd0},
        '{16'haaaa, 16'h5555, 16'h8000, 1'b0, lcs_pkg::ST_OK,      16'd0}
    };

    linear_congruence_solver i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_coef_a         (s_coef_a),
        .s_rhs_b          (s_rhs_b),
        .s_modulus        (s_modulus),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_solution       (m_solution),
        .m_solution_index (m_solution_index),
        .m_last           (m_last),
        .m_truncated      (m_truncated)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Idle length for either side: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Work out every solution of a*x == b (mod m) and queue them in order.
    function automatic void predict_solutions(input word_t a, input word_t b, input word_t m);
        longint unsigned x, y, t, d, ar, br, mr, inv, x0, cnt, k;
        longint          r0, r1, t0, t1, q, nr, nt;
        bit              cut;
        solution_t       sol;
        if (m == 0) begin
            pending_solutions.push_back(solution_t'{lcs_pkg::ST_MODZERO, '0, '0, 1'b1, 1'b0});
            return;
        end
        // Euclid for d = gcd(a, m)
        x = a;
        y = m;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        d = x;
        if (b % d != 0) begin
            pending_solutions.push_back(solution_t'{lcs_pkg::ST_NOSOL, '0, '0, 1'b1, 1'b0});
            return;
        end
        ar = a / d;
        br = b / d;
        mr = m / d;
        // Extended Euclid for the inverse of a' mod m'; take 0 for modulus one.
        inv = 0;
        if (mr > 1) begin
            r0 = longint'(mr);
            r1 = longint'(ar % mr);
            t0 = 0;
            t1 = 1;
            while (r1 != 0) begin
                q  = r0 / r1;
                nr = r0 - q * r1;
                nt = t0 - q * t1;
                r0 = r1;
                r1 = nr;
                t0 = t1;
                t1 = nt;
            end
            if (t0 < 0) t0 += longint'(mr);
            inv = longint'(t0 % longint'(mr));
        end
        x0  = ((br % mr) * inv) % mr;
        cut = (d > MAX_LIST);
        cnt = cut ? MAX_LIST : d;
        for (k = 0; k < cnt; k++) begin
            sol.status    = lcs_pkg::ST_OK;
            sol.solution  = WIDTH'(x0 + mr * k);
            sol.index     = IDX_W'(k);
            sol.last      = (k + 1 == cnt);
            sol.truncated = cut;
            pending_solutions.push_back(sol);
        end
    endfunction

    // Offer one item and hold it until the block takes it. Keep valid high
    // through back-to-back items; drop it only for a gap.
    task automatic offer_item(input word_t a, input word_t b, input word_t m);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_coef_a  <= a;
        s_rhs_b   <= b;
        s_modulus <= m;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold the sender until the block has given back everything it owes.
    task automatic wait_drained();
        while (pending_solutions.size() != 0) @(posedge aclk);
    endtask

    // Compare one taken result with the oldest expectation, field by field.
    task automatic check_solution();
        solution_t want;
        results_seen++;
        if (pending_solutions.size() == 0) begin
            report_mismatch($sformatf("unexpected item status=%0d solution=%0d index=%0d",
                                      m_status, m_solution, m_solution_index));
            return;
        end
        want = pending_solutions.pop_front();
        if (m_status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", m_status, want.status));
        if (m_solution !== want.solution)
            report_mismatch($sformatf("solution got %0d want %0d (index %0d)",
                                      m_solution, want.solution, want.index));
        if (m_solution_index !== want.index)
            report_mismatch($sformatf("index got %0d want %0d", m_solution_index, want.index));
        if (m_last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b (index %0d)",
                                      m_last, want.last, want.index));
        if (m_truncated !== want.truncated)
            report_mismatch($sformatf("truncated got %0b want %0b (index %0d)",
                                      m_truncated, want.truncated, want.index));
    endtask

    // Receiver: take results with random stalls. Once, after a few dozen
    // results, hold off for a long stretch so the block backs up and closes
    // its input while the sender keeps offering.
    initial begin
        int stall_left;
        bit held_long;
        stall_left = 0;
        held_long  = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                check_solution();
                if (!held_long && results_seen == 30) begin
                    stall_left = LONG_HOLD;
                    held_long  = 1'b1;
                end else begin
                    stall_left = pick_gap();
                end
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if it overstays a generous cycle budget.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Sender: reset, directed table, then random items.
    initial begin
        int    n;
        int    kind;
        int    d;
        int    span;
        word_t a, b, m;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_coef_a  <= '0;
        s_rhs_b   <= '0;
        s_modulus <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the table; queue the typed result where one is given.
        for (n = 0; n < NUM_ROWS; n++) begin
            offer_item(congruence_rows[n].coef_a, congruence_rows[n].rhs_b,
                       congruence_rows[n].modulus);
            if (congruence_rows[n].known_result)
                pending_solutions.push_back(solution_t'{congruence_rows[n].status,
                                                        congruence_rows[n].solution,
                                                        '0, 1'b1, 1'b0});
            else
                predict_solutions(congruence_rows[n].coef_a, congruence_rows[n].rhs_b,
                                  congruence_rows[n].modulus);
        end
        s_valid <= 1'b0;
        wait_drained();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            // Run a stretch with no idling on either side.
            calm = (n >= 40 && n < 60);
            // Pause the sender once until the block has emptied out.
            if (n == 60) begin
                s_valid <= 1'b0;
                wait_drained();
            end
            kind = $urandom_range(0, 9);
            // Common factor: mostly small so lists stay short, a few past the limit.
            span = $urandom_range(0, 99);
            d = (span < 70) ? $urandom_range(1, 8) :
                (span < 95) ? $urandom_range(9, 64) : $urandom_range(65, 120);
            if (kind < 4) begin
                // raw noise over the full field range
                a = word_t'($urandom);
                b = word_t'($urandom);
                m = word_t'($urandom);
            end else if (kind < 7) begin
                // a, b, m share the factor d; gcd(a, m) may still exceed d and fail to divide b
                m = word_t'(d * $urandom_range(1, 65535 / d));
                a = word_t'(d * $urandom_range(0, 65535 / d));
                b = word_t'(d * $urandom_range(0, 65535 / d));
            end else if (kind < 9) begin
                // shared factor in a and m, b offset from a multiple of it
                m = word_t'(d * $urandom_range(1, 65535 / d));
                a = word_t'(d * $urandom_range(0, 65535 / d));
                b = word_t'(d * $urandom_range(0, 65535 / d) + $urandom_range(1, 7));
            end else begin
                // modulus zero or tiny
                a = word_t'($urandom);
                b = word_t'($urandom);
                m = word_t'($urandom_range(0, 3));
            end
            offer_item(a, b, m);
            predict_solutions(a, b, m);
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        // Let the tail come out, then watch a while for stray results.
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0 && pending_solutions.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
src/lcs_pkg.sv
src/lcs_divider.sv
src/linear_congruence_solver.sv
tb/linear_congruence_solver_tb.sv
